// ===== rtl/core/cbfm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbfm_pkg
// Shared constants and types of the clock frame manager.
// ----------------------------------------------------------------------------
package cbfm_pkg;

  localparam int Frames   = 16;
  localparam int PinBits  = 8;
  localparam int FrameW   = $clog2(Frames);
  localparam int WalkW    = $clog2(Frames + 2);

  localparam logic [2:0] OpRead    = 3'd0;
  localparam logic [2:0] OpAlloc   = 3'd1;
  localparam logic [2:0] OpUnpin   = 3'd2;
  localparam logic [2:0] OpDispose = 3'd3;
  localparam logic [2:0] OpFlush   = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StExceeded = 2'd1;
  localparam logic [1:0] StNotPin   = 2'd2;
  localparam logic [1:0] StPinned   = 2'd3;

  typedef struct packed {
    logic [3:0]  frame;
    logic        hit;
    logic        need_read;
    logic        writeback;
    logic [7:0]  wb_file;
    logic [31:0] wb_page;
    logic        not_found;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  file_id;
    logic [31:0] page_no;
    logic        dirty_flag;
  } request_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request
    logic lookup;     // execute lookup-based op in one step
    logic walk;       // one clock-hand step
    logic scan;       // one flush scan step
    logic scan_init;  // reset scan index
    logic emit_done;  // emit final result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_end;   // read hit on lookup, or victim installed or walk exhausted, result emitted
    logic scan_end;   // scan finished or stopped
    logic scan_pin;   // scan stopped on a pinned frame, final result emitted
  } stat_t;

endpackage

// ===== rtl/core/clock_buffer_frame_manager_top.sv =====
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager_top
// Clock second-chance frame manager for a 16-frame page buffer pool.
//
//   channel  dir  tdata fields (low to high)                            tuser
//   s_axis   in   opcode[2:0] file_id[10:3] page_no[42:11] dirty_flag[43] -
//   m_axis   out  frame hit need_read writeback wb_file wb_page
//                 not_found status (50 of 56 bits used)                last via tlast
//
// A request is latched, then steps the datapath one action at a time: lookup
// ops take a single lookup step, a read miss or allocate adds a victim walk as
// the clock hand walks one frame a cycle, and a flush scans one frame per cycle
// and then emits the closing result unless it stops on a pinned frame. Every step
// waits while the result queue holds two results, or one not taken in that cycle.
// Reset clears the frame table at once and parks the hand on the last frame.
// ----------------------------------------------------------------------------
module clock_buffer_frame_manager_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // opcode, file_id, page_no, dirty_flag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // frame, hit, need_read, writeback, wb_file,
                                      // wb_page, not_found, status
  output logic        m_axis_tlast
);
  import cbfm_pkg::*;

  request_t req;
  cmd_t     cmd;
  stat_t    stat;
  result_t  res, outr;
  logic     res_valid, busy;

  assign req.opcode     = s_axis_tdata[2:0];
  assign req.file_id    = s_axis_tdata[10:3];
  assign req.page_no    = s_axis_tdata[42:11];
  assign req.dirty_flag = s_axis_tdata[43];

  cbfm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tdata[2:0]),
    .out_busy_i (busy),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  cbfm_dpath u_dpath (
    .clk_i, .rst_ni,
    .req_i       (req),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cbfm_outq u_outq (
    .clk_i, .rst_ni,
    .push_i  (res_valid),
    .data_i  (res),
    .busy_o  (busy),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (outr)
  );

  assign m_axis_tlast = outr.last;
  assign m_axis_tdata = {6'b0, outr.status, outr.not_found, outr.wb_page,
                         outr.wb_file, outr.writeback, outr.need_read, outr.hit,
                         outr.frame};

endmodule

// ===== rtl/core/cbfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbfm_ctrl
// Request sequencer: accepts a request, steps the datapath, waits on output.
// ----------------------------------------------------------------------------
module cbfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        opcode_i,
  input  logic              out_busy_i,
  input  cbfm_pkg::stat_t   stat_i,
  output logic              in_ready_o,
  output cbfm_pkg::cmd_t    cmd_o
);
  import cbfm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_WALK, S_SCAN, S_FINAL} state_e;
  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_DISPATCH: begin
        cmd_o.lookup    = !out_busy_i;
        cmd_o.scan_init = 1'b1;
      end
      S_WALK:  cmd_o.walk = !out_busy_i;
      S_SCAN:  cmd_o.scan = !out_busy_i;
      S_FINAL: cmd_o.emit_done = !out_busy_i;
      default: ;
    endcase
  end

  logic [2:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OpRead;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          op_q    <= opcode_i;
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: if (!out_busy_i) begin
          case (op_q)
            OpFlush: state_q <= S_SCAN;
            OpAlloc: state_q <= S_WALK;
            OpRead:  state_q <= stat_i.walk_end ? S_IDLE : S_WALK;
            default: state_q <= S_IDLE;
          endcase
        end
        S_WALK: if (!out_busy_i && stat_i.walk_end) state_q <= S_IDLE;
        S_SCAN: if (!out_busy_i && stat_i.scan_end) begin
          state_q <= stat_i.scan_pin ? S_IDLE : S_FINAL;
        end
        S_FINAL: if (!out_busy_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/cbfm_dpath.sv =====
// ----------------------------------------------------------------------------
// cbfm_dpath
// Frame table, clock hand, lookup, victim walk and flush scan.
// ----------------------------------------------------------------------------
module cbfm_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cbfm_pkg::request_t req_i,
  input  cbfm_pkg::cmd_t     cmd_i,
  output cbfm_pkg::stat_t    stat_o,
  output logic               res_valid_o,
  output cbfm_pkg::result_t  res_o
);
  import cbfm_pkg::*;

  localparam logic [PinBits-1:0] PinMax = '1;
  localparam logic [FrameW-1:0]  LastFrame = FrameW'(Frames - 1);

  logic [Frames-1:0]        valid_q, ref_q, dirty_q;
  logic [PinBits-1:0]       pins_q [Frames];
  logic [7:0]               file_q [Frames];
  logic [31:0]              page_q [Frames];
  logic [FrameW-1:0]        hand_q, idx_q;
  logic [WalkW-1:0]         steps_q;
  request_t                 req_q;

  logic [Frames-1:0]        match;
  logic                     found;
  logic [FrameW-1:0]        fidx, nh;
  logic                     take;
  logic                     scan_pin;

  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < Frames; i++) begin
      match[i] = valid_q[i] && file_q[i] == req_q.file_id && page_q[i] == req_q.page_no;
    end
    for (int i = Frames - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        fidx  = FrameW'(i);
      end
    end
  end

  assign nh   = (hand_q == LastFrame) ? '0 : hand_q + 1'b1;
  assign take = !valid_q[nh] || (!ref_q[nh] && pins_q[nh] == '0);

  always_comb begin
    scan_pin = valid_q[idx_q] && file_q[idx_q] == req_q.file_id &&
               pins_q[idx_q] != '0;
    stat_o.walk_end = cmd_i.lookup ? (req_q.opcode == OpRead && found)
                                   : (take || steps_q == WalkW'(Frames));
    stat_o.scan_end = (idx_q == LastFrame) || scan_pin;
    stat_o.scan_pin = scan_pin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ref_q       <= '0;
      dirty_q     <= '0;
      hand_q      <= LastFrame;
      res_valid_o <= 1'b0;
      idx_q       <= '0;
      steps_q     <= '0;
      for (int i = 0; i < Frames; i++) begin
        pins_q[i] <= '0;
        file_q[i] <= '0;
        page_q[i] <= '0;
      end
    end else begin
      res_valid_o <= 1'b0;
      if (cmd_i.load) req_q <= req_i;
      if (cmd_i.scan_init) begin
        idx_q   <= '0;
        steps_q <= '0;
      end
      if (cmd_i.lookup) begin
        res_o       <= '0;
        res_o.last  <= 1'b1;
        case (req_q.opcode)
          OpRead: if (found) begin
            ref_q[fidx] <= 1'b1;
            if (pins_q[fidx] != PinMax) pins_q[fidx] <= pins_q[fidx] + 1'b1;
            res_o.frame <= 4'(fidx);
            res_o.hit   <= 1'b1;
            res_valid_o <= 1'b1;
          end
          OpAlloc, OpFlush: ;
          OpUnpin: begin
            res_valid_o <= 1'b1;
            if (!found) res_o.not_found <= 1'b1;
            else begin
              res_o.frame <= 4'(fidx);
              if (pins_q[fidx] == '0) res_o.status <= StNotPin;
              else begin
                pins_q[fidx] <= pins_q[fidx] - 1'b1;
                if (req_q.dirty_flag) dirty_q[fidx] <= 1'b1;
              end
            end
          end
          OpDispose: begin
            res_valid_o <= 1'b1;
            if (!found) res_o.not_found <= 1'b1;
            else begin
              res_o.frame   <= 4'(fidx);
              valid_q[fidx] <= 1'b0;
              ref_q[fidx]   <= 1'b0;
              dirty_q[fidx] <= 1'b0;
              pins_q[fidx]  <= '0;
              file_q[fidx]  <= '0;
              page_q[fidx]  <= '0;
            end
          end
          default: res_valid_o <= 1'b1;
        endcase
      end
      if (cmd_i.walk) begin
        hand_q  <= nh;
        steps_q <= steps_q + 1'b1;
        if (take) begin
          res_o           <= '0;
          res_o.last      <= 1'b1;
          res_o.frame     <= 4'(nh);
          res_o.need_read <= (req_q.opcode == OpRead);
          if (valid_q[nh] && dirty_q[nh]) begin
            res_o.writeback <= 1'b1;
            res_o.wb_file   <= file_q[nh];
            res_o.wb_page   <= page_q[nh];
          end
          res_valid_o <= 1'b1;
          valid_q[nh] <= 1'b1;
          ref_q[nh]   <= 1'b1;
          dirty_q[nh] <= 1'b0;
          pins_q[nh]  <= PinBits'(1);
          file_q[nh]  <= req_q.file_id;
          page_q[nh]  <= req_q.page_no;
        end else begin
          if (valid_q[nh] && ref_q[nh]) ref_q[nh] <= 1'b0;
          if (steps_q == WalkW'(Frames)) begin
            res_o        <= '0;
            res_o.last   <= 1'b1;
            res_o.status <= StExceeded;
            res_valid_o  <= 1'b1;
          end
        end
      end
      if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
        res_o <= '0;
        if (valid_q[idx_q] && file_q[idx_q] == req_q.file_id) begin
          if (pins_q[idx_q] != '0) begin
            res_o.frame  <= 4'(idx_q);
            res_o.status <= StPinned;
            res_o.last   <= 1'b1;
            res_valid_o  <= 1'b1;
          end else begin
            if (dirty_q[idx_q]) begin
              res_o.frame     <= 4'(idx_q);
              res_o.writeback <= 1'b1;
              res_o.wb_file   <= file_q[idx_q];
              res_o.wb_page   <= page_q[idx_q];
              res_valid_o     <= 1'b1;
            end
            valid_q[idx_q] <= 1'b0;
            ref_q[idx_q]   <= 1'b0;
            dirty_q[idx_q] <= 1'b0;
            pins_q[idx_q]  <= '0;
            file_q[idx_q]  <= '0;
            page_q[idx_q]  <= '0;
          end
        end
      end
      if (cmd_i.emit_done) begin
        res_o       <= '0;
        res_o.last  <= 1'b1;
        res_valid_o <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/cbfm_outq.sv =====
// ----------------------------------------------------------------------------
// cbfm_outq
// Two-entry result queue.
// ----------------------------------------------------------------------------
module cbfm_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbfm_pkg::result_t data_i,
  output logic              busy_o,
  output logic              valid_o,
  input  logic              ready_i,
  output cbfm_pkg::result_t data_o
);
  import cbfm_pkg::*;

  result_t    mem_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];
  assign busy_o  = cnt_q == 2'd2 || (cnt_q == 2'd1 && !pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push_i) begin
        mem_q[wr_q] <= data_i;
        wr_q        <= ~wr_q;
      end
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the clock frame manager. A local page table predicts
// every response (hits, clock victims, writebacks, flush scans, error cases);
// a scoreboard checks each response, all fields compared together, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbfm_pkg::*;

  class frame_scoreboard;
    logic        vld   [Frames];
    logic        ref_b [Frames];
    logic        dirty [Frames];
    int unsigned pins  [Frames];
    logic [7:0]  file  [Frames];
    logic [31:0] page  [Frames];
    logic [3:0]  hand;
    result_t     pending[$];
    int          errors;

    function new();
      for (int f = 0; f < Frames; f++) wipe(f);
      hand = 4'(Frames - 1);
      errors = 0;
    endfunction

    function void wipe(int f);
      vld[f] = 0; ref_b[f] = 0; dirty[f] = 0; pins[f] = 0; file[f] = 0; page[f] = 0;
    endfunction

    function int find_page(logic [7:0] fi, logic [31:0] pg);
      for (int f = 0; f < Frames; f++)
        if (vld[f] && file[f] == fi && page[f] == pg) return f;
      return -1;
    endfunction

    function void push(logic [3:0] fr, logic h, logic nr, logic wb, logic [7:0] wf,
                       logic [31:0] wp, logic nf, logic [1:0] st, logic l);
      result_t r;
      r.frame = fr; r.hit = h; r.need_read = nr; r.writeback = wb; r.wb_file = wf;
      r.wb_page = wp; r.not_found = nf; r.status = st; r.last = l;
      pending.push_back(r);
    endfunction

    function void install(logic [7:0] fi, logic [31:0] pg, logic nr);
      int v;
      logic wb;
      logic [7:0] wf;
      logic [31:0] wp;
      v = -1;
      for (int n = 0; n <= Frames; n++) begin
        hand = 4'((hand + 1) % Frames);
        if (!vld[hand]) begin v = hand; break; end
        if (ref_b[hand]) begin ref_b[hand] = 0; continue; end
        if (pins[hand] == 0) begin v = hand; break; end
      end
      if (v < 0) begin
        push(0, 0, 0, 0, 0, 0, 0, StExceeded, 1);
        return;
      end
      wb = vld[v] && dirty[v];
      wf = wb ? file[v] : 8'd0;
      wp = wb ? page[v] : 32'd0;
      wipe(v);
      vld[v] = 1; ref_b[v] = 1; pins[v] = 1; file[v] = fi; page[v] = pg;
      push(4'(v), 0, nr, wb, wf, wp, 0, StOk, 1);
    endfunction

    function void note_request(request_t q);
      int f;
      case (q.opcode)
        OpRead: begin
          f = find_page(q.file_id, q.page_no);
          if (f >= 0) begin
            ref_b[f] = 1;
            if (pins[f] < (1 << PinBits) - 1) pins[f]++;
            push(4'(f), 1, 0, 0, 0, 0, 0, StOk, 1);
          end else install(q.file_id, q.page_no, 1);
        end
        OpAlloc: install(q.file_id, q.page_no, 0);
        OpUnpin: begin
          f = find_page(q.file_id, q.page_no);
          if (f < 0) push(0, 0, 0, 0, 0, 0, 1, StOk, 1);
          else if (pins[f] == 0) push(4'(f), 0, 0, 0, 0, 0, 0, StNotPin, 1);
          else begin
            pins[f]--;
            if (q.dirty_flag) dirty[f] = 1;
            push(4'(f), 0, 0, 0, 0, 0, 0, StOk, 1);
          end
        end
        OpDispose: begin
          f = find_page(q.file_id, q.page_no);
          if (f < 0) push(0, 0, 0, 0, 0, 0, 1, StOk, 1);
          else begin
            wipe(f);
            push(4'(f), 0, 0, 0, 0, 0, 0, StOk, 1);
          end
        end
        OpFlush: begin
          for (f = 0; f < Frames; f++) begin
            if (!vld[f] || file[f] != q.file_id) continue;
            if (pins[f] > 0) begin
              push(4'(f), 0, 0, 0, 0, 0, 0, StPinned, 1);
              return;
            end
            if (dirty[f]) push(4'(f), 0, 0, 1, file[f], page[f], 0, StOk, 0);
            wipe(f);
          end
          push(0, 0, 0, 0, 0, 0, 0, StOk, 1);
        end
        default: push(0, 0, 0, 0, 0, 0, 0, StOk, 1);
      endcase
    endfunction

    function void check_response(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  frame_scoreboard sb = new();
  bit no_idle;
  bit hold_off;

  clock_buffer_frame_manager_top uut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // accepted traffic, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(request_t'({s_axis_tdata[2:0], s_axis_tdata[10:3],
                                  s_axis_tdata[42:11], s_axis_tdata[43]}));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_t r;
      r.frame = m_axis_tdata[3:0]; r.hit = m_axis_tdata[4];
      r.need_read = m_axis_tdata[5]; r.writeback = m_axis_tdata[6];
      r.wb_file = m_axis_tdata[14:7]; r.wb_page = m_axis_tdata[46:15];
      r.not_found = m_axis_tdata[47]; r.status = m_axis_tdata[49:48];
      r.last = m_axis_tlast;
      sb.check_response(r);
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (200) @(negedge clk_i);
        hold_off = 0;
      end
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  task automatic send_request(logic [2:0] op, logic [7:0] fi, logic [31:0] pg, logic df);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'd0, df, pg, fi, op};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  logic [7:0]  used_file [$];
  logic [31:0] used_page [$];

  task automatic random_request();
    int k, pick;
    logic [7:0] fi;
    logic [31:0] pg;
    k = $urandom_range(0, 99);
    pick = used_file.size() ? $urandom_range(0, used_file.size() - 1) : 0;
    if (used_file.size() && $urandom_range(0, 3) != 0) begin
      fi = used_file[pick]; pg = used_page[pick];
    end else begin
      fi = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
      pg = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 20));
      used_file.push_back(fi); used_page.push_back(pg);
      if (used_file.size() > 40) begin
        void'(used_file.pop_front()); void'(used_page.pop_front());
      end
    end
    if (k < 35) send_request(OpRead, fi, pg, 0);
    else if (k < 45) send_request(OpAlloc, fi, pg, 0);
    else if (k < 78) send_request(OpUnpin, fi, pg, 1'($urandom));
    else if (k < 88) send_request(OpDispose, fi, pg, 0);
    else if (k < 97) send_request(OpFlush, fi, pg, 1'($urandom));
    else send_request(3'($urandom_range(5, 7)), fi, pg, 1'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: extremes, every operation, error paths
    send_request(OpUnpin, 8'd0, 32'd0, 0);
    send_request(OpDispose, 8'hff, 32'hffff_ffff, 0);
    send_request(OpRead, 8'hff, 32'hffff_ffff, 0);
    send_request(OpRead, 8'hff, 32'hffff_ffff, 0);
    send_request(OpUnpin, 8'hff, 32'hffff_ffff, 1);
    send_request(OpUnpin, 8'hff, 32'hffff_ffff, 1);
    send_request(OpUnpin, 8'hff, 32'hffff_ffff, 0);
    send_request(OpAlloc, 8'hff, 32'hffff_ffff, 0);
    send_request(OpFlush, 8'hff, 32'd0, 0);
    send_request(OpRead, 8'hff, 32'hffff_ffff, 0);
    send_request(OpFlush, 8'hff, 32'd0, 0);
    for (int i = 0; i < 17; i++) send_request(OpAlloc, 8'h5a, 32'(i), 0);
    send_request(OpDispose, 8'h5a, 32'd3, 0);
    for (int i = 0; i < 3; i++) send_request(3'(5 + i), 8'h5a, 32'd0, 1);
    // pin count saturation on one frame
    for (int i = 0; i < 258; i++) send_request(OpRead, 8'h5a, 32'd4, 0);
    for (int i = 0; i < 16; i++) begin
      send_request(OpUnpin, 8'h5a, 32'(i), 1);
      send_request(OpUnpin, 8'h5a, 32'(i), 0);
    end
    send_request(OpFlush, 8'h5a, 32'd0, 0);
    for (int i = 0; i < 8; i++) send_request(OpUnpin, 8'h5a, 32'd4, 1);
    send_request(OpFlush, 8'h5a, 32'd0, 0);
    hold_off = 1;
    for (int i = 0; i < 140; i++) begin
      if (i == 110) no_idle = 1;
      random_request();
    end
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/cbfm_pkg.sv
rtl/core/cbfm_ctrl.sv
rtl/core/cbfm_dpath.sv
rtl/core/cbfm_outq.sv
rtl/core/clock_buffer_frame_manager_top.sv
sim/tb_top.sv
